// File: rtl/core/chtd_pkg.sv
//------------------------------------------------------------------------------
// chtd_pkg
// Shared types and constants of the canonical huffman table decoder.
//------------------------------------------------------------------------------
`default_nettype none

package chtd_pkg;

   localparam int MAX_CODE_LENGTH_DEF = 12;
   localparam int ALPHABET_SIZE_DEF   = 256;

   localparam logic [1:0] MODE_LOAD_COUNT  = 2'd0;
   localparam logic [1:0] MODE_LOAD_SYMBOL = 2'd1;
   localparam logic [1:0] MODE_START       = 2'd2;
   localparam logic [1:0] MODE_DATA        = 2'd3;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CLEAR,
      S_LEN,
      S_CODE,
      S_FILL,
      S_LOOK,
      S_EVAL,
      S_FLUSH
   } state_type;

   typedef struct packed {
      logic load_count;
      logic load_symbol;
      logic start_frame;
      logic take_word;
      logic clear_write;
      logic len_begin;
      logic len_next;
      logic code_begin;
      logic fill_write;
      logic code_next;
      logic eval_emit;
      logic flush;
   } cmd_type;

   typedef struct packed {
      logic stopped;
      logic clear_last;
      logic len_over;
      logic cnt_zero;
      logic fill_last;
      logic code_full;
      logic cnt_done;
      logic short_buffer;
      logic terminal;
      logic hold_valid;
      logic out_free;
   } status_type;

endpackage

`default_nettype wire

// File: rtl/core/canonical_huffman_table_decoder.sv
// loads are taken from the idle state; a start clears every lookup-memory entry, then
// per code length and per code writes 2^MAX_CODE_LENGTH >> length lookup-memory entries;
// a data word is accepted, then each decoded byte takes a lookup and an evaluate step before
// the word closes, stalled while rsp_ready holds the result register; one word is in flight at a time
// reset clears control state, the bit buffer and the counters; the frame starts stopped
// and the lookup memory is rebuilt by every start, so it is not swept at reset
//------------------------------------------------------------------------------
// canonical_huffman_table_decoder
// Canonical huffman byte decoder with a direct lookup memory, lsb-first stream.
//------------------------------------------------------------------------------
`default_nettype none

module canonical_huffman_table_decoder #(
   parameter int MAX_CODE_LENGTH = chtd_pkg::MAX_CODE_LENGTH_DEF,
   parameter int ALPHABET_SIZE   = chtd_pkg::ALPHABET_SIZE_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_mode,
   input  wire logic [7:0]  req_slot,
   input  wire logic [8:0]  req_load_value,
   input  wire logic [31:0] req_data_word,
   input  wire logic [23:0] req_symbol_total,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [7:0]       rsp_symbol,
   output logic             rsp_last_of_word,
   output logic             rsp_frame_done,
   output logic             rsp_decode_error
);
   import chtd_pkg::*;

   cmd_type    cmd;
   status_type status;

   chtd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_mode  (req_mode),
      .status    (status),
      .cmd       (cmd)
   );

   chtd_datapath #(
      .MAX_CODE_LENGTH (MAX_CODE_LENGTH),
      .ALPHABET_SIZE   (ALPHABET_SIZE)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_slot         (req_slot),
      .req_load_value   (req_load_value),
      .req_data_word    (req_data_word),
      .req_symbol_total (req_symbol_total),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_symbol       (rsp_symbol),
      .rsp_last_of_word (rsp_last_of_word),
      .rsp_frame_done   (rsp_frame_done),
      .rsp_decode_error (rsp_decode_error)
   );

endmodule

`default_nettype wire

// File: rtl/core/chtd_ctrl.sv
//------------------------------------------------------------------------------
// chtd_ctrl
// Controller: sequences loads, table build and per-byte decode steps.
//------------------------------------------------------------------------------
`default_nettype none

module chtd_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic [1:0]           req_mode,
   input  wire chtd_pkg::status_type status,
   output chtd_pkg::cmd_type         cmd
);
   import chtd_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = (state_ff == S_IDLE);
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               case (req_mode)
                  MODE_LOAD_COUNT: begin
                     cmd.load_count = 1'b1;
                  end
                  MODE_LOAD_SYMBOL: begin
                     cmd.load_symbol = 1'b1;
                  end
                  MODE_START: begin
                     cmd.start_frame = 1'b1;
                     state_in        = S_CLEAR;
                  end
                  MODE_DATA: begin
                     if (!status.stopped) begin
                        cmd.take_word = 1'b1;
                        state_in      = S_LOOK;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_CLEAR: begin
            cmd.clear_write = 1'b1;
            if (status.clear_last) begin
               state_in = S_LEN;
            end
         end
         S_LEN: begin
            if (status.len_over) begin
               state_in = S_IDLE;
            end else if (status.cnt_zero) begin
               cmd.len_next = 1'b1;
            end else begin
               cmd.len_begin = 1'b1;
               state_in      = S_CODE;
            end
         end
         S_CODE: begin
            cmd.code_begin = 1'b1;
            state_in       = S_FILL;
         end
         S_FILL: begin
            cmd.fill_write = 1'b1;
            if (status.fill_last) begin
               cmd.code_next = 1'b1;
               if (status.code_full) begin
                  state_in = S_IDLE;
               end else if (status.cnt_done) begin
                  cmd.len_next = 1'b1;
                  state_in     = S_LEN;
               end else begin
                  state_in = S_CODE;
               end
            end
         end
         S_LOOK: begin
            state_in = S_EVAL;
         end
         S_EVAL: begin
            if (status.short_buffer) begin
               state_in = status.hold_valid ? S_FLUSH : S_IDLE;
            end else if (!status.hold_valid || status.out_free) begin
               cmd.eval_emit = 1'b1;
               state_in      = status.terminal ? S_FLUSH : S_LOOK;
            end
         end
         S_FLUSH: begin
            if (status.out_free) begin
               cmd.flush = 1'b1;
               state_in  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// File: rtl/core/chtd_datapath.sv
//------------------------------------------------------------------------------
// chtd_datapath
// Datapath: code tables, lookup memory, bit buffer and result registers.
//------------------------------------------------------------------------------
`default_nettype none

module chtd_datapath #(
   parameter int MAX_CODE_LENGTH = chtd_pkg::MAX_CODE_LENGTH_DEF,
   parameter int ALPHABET_SIZE   = chtd_pkg::ALPHABET_SIZE_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire chtd_pkg::cmd_type    cmd,
   output chtd_pkg::status_type      status,
   input  wire logic [7:0]           req_slot,
   input  wire logic [8:0]           req_load_value,
   input  wire logic [31:0]          req_data_word,
   input  wire logic [23:0]          req_symbol_total,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic [7:0]                rsp_symbol,
   output logic                      rsp_last_of_word,
   output logic                      rsp_frame_done,
   output logic                      rsp_decode_error
);
   import chtd_pkg::*;

   localparam int TABLE_SIZE = 1 << MAX_CODE_LENGTH;
   localparam int KW         = MAX_CODE_LENGTH + 1;
   localparam int LENW       = $clog2(MAX_CODE_LENGTH + 2);
   localparam int CIW        = (MAX_CODE_LENGTH > 1) ? $clog2(MAX_CODE_LENGTH) : 1;

   logic [8:0]                 counts_ff [MAX_CODE_LENGTH];
   logic [7:0]                 sym_mem [256];
   logic [7:0]                 sym_rd_ff;
   logic [13:0]                tbl_mem [TABLE_SIZE];
   logic [13:0]                tbl_rd_ff;

   logic [LENW-1:0]            len_ff, len_in;
   logic [KW-1:0]              code_ff, code_in;
   logic [7:0]                 pos_ff, pos_in;
   logic                       pos_empty_ff, pos_empty_in;
   logic [8:0]                 c_ff, c_in;
   logic [KW-1:0]              k_ff, k_in;
   logic [MAX_CODE_LENGTH-1:0] clr_ff, clr_in;

   logic [63:0]                buffer_ff, buffer_in;
   logic [6:0]                 held_ff, held_in;
   logic [23:0]                bytes_ff, bytes_in;
   logic [23:0]                target_ff, target_in;
   logic                       stopped_ff, stopped_in;
   logic [5:0]                 n_ff, n_in;

   logic                       hold_valid_ff, hold_valid_in;
   logic [7:0]                 hold_sym_ff, hold_sym_in;
   logic                       hold_done_ff, hold_done_in;
   logic                       hold_err_ff, hold_err_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic [7:0]                 rsp_sym_ff, rsp_sym_in;
   logic                       rsp_last_ff, rsp_last_in;
   logic                       rsp_done_ff, rsp_done_in;
   logic                       rsp_err_ff, rsp_err_in;

   logic [8:0]                 cnt;
   logic [MAX_CODE_LENGTH-1:0] code_rev;
   logic [MAX_CODE_LENGTH-1:0] base;
   logic [KW-1:0]              step;
   logic [KW-1:0]              k_sum;
   logic [KW-1:0]              code_inc;
   logic [13:0]                entry;
   logic                       wr_en;
   logic [MAX_CODE_LENGTH-1:0] wr_addr;
   logic [13:0]                wr_data;
   logic [4:0]                 ent_len;
   logic                       ent_valid;
   logic [4:0]                 need;
   logic                       is_done;
   logic                       out_free;
   logic                       push;

   // symbol list and code counts
   always_ff @(posedge clock) begin
      if (cmd.load_symbol) begin
         sym_mem[req_slot] <= req_load_value[7:0];
      end
      sym_rd_ff <= sym_mem[pos_ff];
      if (cmd.load_count && (req_slot != 8'd0) && (req_slot <= 8'(MAX_CODE_LENGTH))) begin
         counts_ff[CIW'(req_slot - 8'd1)] <= req_load_value;
      end
   end

   // lookup memory
   always_ff @(posedge clock) begin
      if (wr_en) begin
         tbl_mem[wr_addr] <= wr_data;
      end
      tbl_rd_ff <= tbl_mem[buffer_ff[MAX_CODE_LENGTH-1:0]];
   end

   always_comb begin
      for (int i = 0; i < MAX_CODE_LENGTH; i++) begin
         code_rev[i] = code_ff[MAX_CODE_LENGTH-1-i];
      end
   end

   assign cnt      = counts_ff[CIW'(len_ff - LENW'(1))];
   assign base     = code_rev >> (LENW'(MAX_CODE_LENGTH) - len_ff);
   assign step     = KW'(1) << len_ff;
   assign k_sum    = k_ff + step;
   assign code_inc = code_ff + KW'(1);
   assign entry    = {!pos_empty_ff, 5'(len_ff), pos_empty_ff ? 8'd0 : sym_rd_ff};
   assign wr_en    = cmd.clear_write | cmd.fill_write;
   assign wr_addr  = cmd.clear_write ? clr_ff : k_ff[MAX_CODE_LENGTH-1:0];
   assign wr_data  = cmd.clear_write ? 14'd0 : entry;

   assign ent_len   = tbl_rd_ff[12:8];
   assign ent_valid = tbl_rd_ff[13];
   assign need      = (ent_len != 5'd0) ? ent_len : 5'(MAX_CODE_LENGTH);
   assign is_done   = ent_valid && ((bytes_ff + 24'd1) == target_ff);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign push      = (cmd.eval_emit && hold_valid_ff) || cmd.flush;

   always_comb begin
      status.stopped      = stopped_ff;
      status.clear_last   = &clr_ff;
      status.len_over     = len_ff > LENW'(MAX_CODE_LENGTH);
      status.cnt_zero     = (cnt == 9'd0);
      status.fill_last    = k_sum[MAX_CODE_LENGTH];
      status.code_full    = (code_inc == step);
      status.cnt_done     = ({1'b0, c_ff} + 10'd1) == {1'b0, cnt};
      status.short_buffer = held_ff < {2'b00, need};
      status.terminal     = !ent_valid || is_done || (n_ff == 6'd31);
      status.hold_valid   = hold_valid_ff;
      status.out_free     = out_free;
   end

   // build sequencing
   always_comb begin
      len_in       = len_ff;
      code_in      = code_ff;
      pos_in       = pos_ff;
      pos_empty_in = pos_empty_ff;
      c_in         = c_ff;
      k_in         = k_ff;
      clr_in       = clr_ff;
      if (cmd.start_frame) begin
         len_in       = LENW'(1);
         code_in      = '0;
         pos_in       = 8'(ALPHABET_SIZE - 1);
         pos_empty_in = 1'b0;
         clr_in       = '0;
      end
      if (cmd.clear_write) begin
         clr_in = clr_ff + 1'b1;
      end
      if (cmd.len_begin) begin
         c_in = 9'd0;
      end
      if (cmd.code_begin) begin
         k_in = {1'b0, base};
      end
      if (cmd.fill_write) begin
         k_in = k_sum;
      end
      if (cmd.code_next) begin
         pos_in       = pos_ff - 8'd1;
         pos_empty_in = pos_empty_ff || (pos_ff == 8'd0);
         c_in         = c_ff + 9'd1;
         code_in      = code_inc;
      end
      if (cmd.len_next) begin
         len_in  = len_ff + LENW'(1);
         code_in = {code_in[KW-2:0], 1'b0};
      end
   end

   // decode and result staging
   always_comb begin
      buffer_in     = buffer_ff;
      held_in       = held_ff;
      bytes_in      = bytes_ff;
      target_in     = target_ff;
      stopped_in    = stopped_ff;
      n_in          = n_ff;
      hold_valid_in = hold_valid_ff;
      hold_sym_in   = hold_sym_ff;
      hold_done_in  = hold_done_ff;
      hold_err_in   = hold_err_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_sym_in    = rsp_sym_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_done_in   = rsp_done_ff;
      rsp_err_in    = rsp_err_ff;

      if (cmd.start_frame) begin
         buffer_in  = '0;
         held_in    = '0;
         bytes_in   = '0;
         target_in  = req_symbol_total;
         stopped_in = (req_symbol_total == 24'd0);
      end
      if (cmd.take_word) begin
         buffer_in     = buffer_ff | ({32'd0, req_data_word} << held_ff[4:0]);
         held_in       = held_ff + 7'd32;
         n_in          = '0;
         hold_valid_in = 1'b0;
      end
      if (cmd.eval_emit) begin
         hold_valid_in = 1'b1;
         hold_sym_in   = ent_valid ? tbl_rd_ff[7:0] : 8'd0;
         hold_err_in   = !ent_valid;
         hold_done_in  = is_done;
         n_in          = n_ff + 6'd1;
         if (ent_valid) begin
            bytes_in = bytes_ff + 24'd1;
         end
         if (!ent_valid || is_done) begin
            stopped_in = 1'b1;
            buffer_in  = '0;
            held_in    = '0;
         end else begin
            buffer_in = buffer_ff >> ent_len;
            held_in   = held_ff - {2'b00, ent_len};
         end
      end
      if (cmd.flush) begin
         hold_valid_in = 1'b0;
      end

      if (push) begin
         rsp_valid_in = 1'b1;
         rsp_sym_in   = hold_sym_ff;
         rsp_last_in  = cmd.flush;
         rsp_done_in  = hold_done_ff;
         rsp_err_in   = hold_err_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         buffer_ff     <= '0;
         held_ff       <= '0;
         bytes_ff      <= '0;
         target_ff     <= '0;
         stopped_ff    <= 1'b1;
         n_ff          <= '0;
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         len_ff        <= LENW'(1);
         code_ff       <= '0;
         pos_ff        <= '0;
         pos_empty_ff  <= 1'b0;
         c_ff          <= '0;
         k_ff          <= '0;
         clr_ff        <= '0;
      end else begin
         buffer_ff     <= buffer_in;
         held_ff       <= held_in;
         bytes_ff      <= bytes_in;
         target_ff     <= target_in;
         stopped_ff    <= stopped_in;
         n_ff          <= n_in;
         hold_valid_ff <= hold_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         len_ff        <= len_in;
         code_ff       <= code_in;
         pos_ff        <= pos_in;
         pos_empty_ff  <= pos_empty_in;
         c_ff          <= c_in;
         k_ff          <= k_in;
         clr_ff        <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_sym_ff  <= hold_sym_in;
      hold_done_ff <= hold_done_in;
      hold_err_ff  <= hold_err_in;
      rsp_sym_ff   <= rsp_sym_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_done_ff  <= rsp_done_in;
      rsp_err_ff   <= rsp_err_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_symbol       = rsp_sym_ff;
   assign rsp_last_of_word = rsp_last_ff;
   assign rsp_frame_done   = rsp_done_ff;
   assign rsp_decode_error = rsp_err_ff;

   a_held_bound: assert property (@(posedge clock) disable iff (reset)
      held_ff <= 7'd47)
      else $error("bit buffer holds too many bits");

   a_word_live_frame: assert property (@(posedge clock) disable iff (reset)
      cmd.take_word |-> !stopped_ff)
      else $error("data word taken on a stopped frame");

   a_flush_has_hold: assert property (@(posedge clock) disable iff (reset)
      cmd.flush |-> hold_valid_ff)
      else $error("flush without a held result");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      (cmd.eval_emit && hold_valid_ff) |-> out_free)
      else $error("held result pushed onto a full output register");

endmodule

`default_nettype wire
